FILE: sv/ads_pkg.sv
// ----------------------------------------------------------------------------
// ads_pkg
// Types, register codes and fixed-point constants for the distortion
// waveshaper.
// ----------------------------------------------------------------------------
package ads_pkg;

  // sample and register types
  typedef logic signed [15:0] sample_t;
  typedef logic [15:0]        gain_t;
  typedef logic [1:0]         mode_t;
  typedef logic [0:0]         cfg_idx_t;
  typedef logic [15:0]        cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_GAIN = 1'd0;
  localparam cfg_idx_t REG_MODE = 1'd1;

  // register reset values
  localparam gain_t GAIN_RESET = 16'd4096;
  localparam mode_t MODE_RESET = 2'd3;

  // operating modes
  localparam mode_t MODE_SOFT   = 2'd0;
  localparam mode_t MODE_HARD   = 2'd1;
  localparam mode_t MODE_CRUSH  = 2'd2;
  localparam mode_t MODE_BYPASS = 2'd3;

  // hard clip level, floor(0.55 * 32768)
  localparam int HARD_LIMIT = 18022;

  // gained sample is clamped to this before the cubic, well past the point
  // where the soft clip output saturates
  localparam int G_W     = 18;
  localparam int G_CLAMP = (1 << (G_W - 1)) - 1;

  // divide by 3 through a reciprocal: floor(n/3) = (n * MAGIC3) >> 25 for n < 2^25
  localparam int DIV3_W     = 24;
  localparam int DIV3_SHIFT = 25;
  localparam logic [DIV3_W-1:0] DIV3_MAGIC = DIV3_W'(((1 << DIV3_SHIFT) + 2) / 3);

  // bit crusher geometry
  localparam int CRUSH_BITS  = 4;
  localparam int CRUSH_M     = (1 << CRUSH_BITS) - 1;
  localparam int CRUSH_HALF  = CRUSH_M / 2;
  localparam int CRUSH_K_W   = CRUSH_BITS + 1;
  localparam int CRUSH_N_W   = CRUSH_BITS + 16;
  localparam int CRUSH_SHIFT = 2 * CRUSH_BITS + 16;
  localparam int CRUSH_R_W   = CRUSH_BITS + 18;
  localparam int CRUSH_P_W   = CRUSH_N_W + CRUSH_R_W;
  localparam logic [CRUSH_R_W-1:0] CRUSH_RECIP =
    CRUSH_R_W'(((64'd1 << CRUSH_SHIFT) + 64'(CRUSH_M) - 64'd1) / 64'(CRUSH_M));

endpackage

FILE: sv/ads_in_if.sv
// ----------------------------------------------------------------------------
// ads_in_if
// Input sample channel: valid/ready handshake with one Q1.15 sample.
// ----------------------------------------------------------------------------
interface ads_in_if;
  logic              valid;
  logic              ready;
  ads_pkg::sample_t  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: sv/ads_out_if.sv
// ----------------------------------------------------------------------------
// ads_out_if
// Output sample channel: valid/ready handshake with one Q1.15 sample.
// ----------------------------------------------------------------------------
interface ads_out_if;
  logic              valid;
  logic              ready;
  ads_pkg::sample_t  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: sv/audio_distortion_waveshaper.sv
// an accepted input beat passes the stage 1 to 4 registers, then the output register
// throughput: one beat per cycle, set by the five-stage pipeline which
//   advances whenever the output register is empty or being taken
// reset (synchronous, rst high): pipeline emptied, gain back to unity,
//   mode back to bypass
// ----------------------------------------------------------------------------
// audio_distortion_waveshaper
// Cubic soft clip, hard clip, bit crusher or bypass on Q1.15 samples,
// selected by the mode register, with a Q4.12 input gain.
// ----------------------------------------------------------------------------
module audio_distortion_waveshaper (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  ads_pkg::cfg_idx_t   cfg_index,
  input  ads_pkg::cfg_data_t  cfg_data,
  ads_in_if.sink              samples,
  ads_out_if.source           results
);
  import ads_pkg::*;

  // configuration registers
  gain_t gain;
  mode_t mode;

  // pipeline valid bits
  logic v1, v2, v3, v4, v5;
  logic adv;

  // stage 1
  mode_t                  mode1;
  sample_t                x1;
  logic signed [32:0]     p1;
  logic [CRUSH_K_W-1:0]   k1;

  // stage 2
  mode_t                  mode2;
  sample_t                x2;
  logic signed [G_W-1:0]  gc2;
  logic signed [35:0]     sq2;
  logic [CRUSH_P_W-1:0]   cp2;

  // stage 3
  mode_t                  mode3;
  sample_t                x3;
  logic signed [G_W-1:0]  gc3;
  logic signed [53:0]     cube3;
  sample_t                cr3;

  // stage 4
  mode_t                  mode4;
  sample_t                x4;
  logic signed [G_W-1:0]  gc4;
  logic [47:0]            prod4;
  sample_t                cr4;

  // output register
  sample_t                sample_out;

  // combinational helpers
  logic signed [32:0]         x_ext, gain_ext, p_next;
  logic [CRUSH_BITS+16:0]     cu_prod;
  logic [15:0]                cu;
  logic signed [32:0]         g_full;
  logic signed [G_W-1:0]      gc_next;
  logic signed [35:0]         gc_ext36;
  logic [CRUSH_N_W-1:0]       cn;
  logic signed [53:0]         sq_ext, gc_ext54;
  logic [16:0]                cq;
  logic signed [53:0]         cube_bias;
  logic [DIV3_W-1:0]          m_off;
  logic [22:0]                q3;
  logic signed [23:0]         q_s, r_soft;
  logic signed [23:0]         gc_ext24;
  sample_t                    soft_r, hard_r, r_next;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
      mode <= MODE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GAIN: gain <= cfg_data;
        REG_MODE: mode <= cfg_data[1:0];
        default:  ;
      endcase
    end
  end

  // pipeline moves whenever the output register can take a beat
  assign adv           = !v5 || results.ready;
  assign samples.ready = adv;
  assign results.valid = v5;
  assign results.sample_out = sample_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (adv) begin
      v1 <= samples.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 1: gain product and first crusher quantisation
  always_comb begin
    x_ext    = {{17{samples.sample_in[15]}}, samples.sample_in};
    gain_ext = {17'd0, gain};
    p_next   = x_ext * gain_ext;
    cu       = {~samples.sample_in[15], samples.sample_in[14:0]};
    cu_prod  = {{(CRUSH_BITS+1){1'b0}}, cu} * (CRUSH_BITS+17)'(CRUSH_M)
               + (CRUSH_BITS+17)'(1 << 14);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1 <= mode;
      x1    <= samples.sample_in;
      p1    <= p_next;
      k1    <= cu_prod[15 +: CRUSH_K_W];
    end
  end

  // stage 2: round the gained sample, clamp, square; crusher step rescale
  always_comb begin
    g_full = (p1 + 33'sd2048) >>> 12;
    if (g_full > 33'(G_CLAMP)) begin
      gc_next = G_W'(G_CLAMP);
    end else if (g_full < -33'(G_CLAMP)) begin
      gc_next = -G_W'(G_CLAMP);
    end else begin
      gc_next = g_full[G_W-1:0];
    end
    gc_ext36 = {{(36-G_W){gc_next[G_W-1]}}, gc_next};
    cn       = {k1, 15'd0} + CRUSH_N_W'(CRUSH_HALF);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode2 <= mode1;
      x2    <= x1;
      gc2   <= gc_next;
      sq2   <= gc_ext36 * gc_ext36;
      cp2   <= {{CRUSH_R_W{1'b0}}, cn} * {{CRUSH_N_W{1'b0}}, CRUSH_RECIP};
    end
  end

  // stage 3: cube; crusher level back to a sample, top step saturated
  always_comb begin
    sq_ext   = {{18{sq2[35]}}, sq2};
    gc_ext54 = {{(54-G_W){gc2[G_W-1]}}, gc2};
    cq       = cp2[CRUSH_SHIFT +: 17];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode3 <= mode2;
      x3    <= x2;
      gc3   <= gc2;
      cube3 <= sq_ext * gc_ext54;
      cr3   <= cq[16] ? 16'sh7fff : {~cq[15], cq[14:0]};
    end
  end

  // stage 4: cube / 2^30 rounded, offset positive, times reciprocal of 3
  always_comb begin
    cube_bias = cube3 + 54'sd1610612736;
    m_off     = cube_bias[53:30] + DIV3_W'(3 << 21);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode4 <= mode3;
      x4    <= x3;
      gc4   <= gc3;
      prod4 <= {24'd0, m_off} * {24'd0, DIV3_MAGIC};
      cr4   <= cr3;
    end
  end

  // stage 5: soft clip subtraction and saturation, hard clip, mode select
  always_comb begin
    q3       = prod4[DIV3_SHIFT +: 23];
    q_s      = $signed({1'b0, q3}) - 24'sd2097152;
    gc_ext24 = {{(24-G_W){gc4[G_W-1]}}, gc4};
    r_soft   = gc_ext24 - q_s;
    if (r_soft > 24'sd32767) begin
      soft_r = 16'sh7fff;
    end else if (r_soft < -24'sd32768) begin
      soft_r = 16'sh8000;
    end else begin
      soft_r = r_soft[15:0];
    end
    if (gc4 > G_W'(HARD_LIMIT)) begin
      hard_r = 16'(HARD_LIMIT);
    end else if (gc4 < -G_W'(HARD_LIMIT)) begin
      hard_r = -16'(HARD_LIMIT);
    end else begin
      hard_r = gc4[15:0];
    end
    unique case (mode4)
      MODE_SOFT:  r_next = soft_r;
      MODE_HARD:  r_next = hard_r;
      MODE_CRUSH: r_next = cr4;
      default:    r_next = x4;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sample_out <= r_next;
    end
  end

  // output is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("output valid after reset");

  // input back-pressure only comes from a stalled output beat
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (results.valid && !results.ready))
    else $error("input stalled without output stall");

  // hard clip beats stay within the clip level
  a_hard_bound: assert property (@(posedge clk) disable iff (rst)
    (adv && v4 && mode4 == MODE_HARD) |=>
      (sample_out <= 16'sd18022 && sample_out >= -16'sd18022))
    else $error("hard clip output beyond limit");

endmodule
